@@ sv/ckbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ckbm_pkg
// Shared types and fixed widths of the border-mean chroma key block.
// ---------------------------------------------------------------------------
package ckbm_pkg;

   localparam int CHAN_W = 8;   // one color component
   localparam int POS_W  = 8;   // row or column index
   localparam int THR_W  = 13;  // distance threshold, 4 fractional bits

   // pass selector carried with each input transaction
   localparam logic KIND_CAL = 1'b0;
   localparam logic KIND_KEY = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   // handshake status of the queue as seen by its producer and consumer
   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

endpackage : ckbm_pkg
`default_nettype wire

@@ sv/ckbm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ckbm_front
// Accept pixels: accumulate border sums in the calibration pass, and for
// keying pixels compute per-channel distances from the border mean.
// ---------------------------------------------------------------------------
module ckbm_front #(
   parameter int SIDE  = 256,
   parameter int SUM_W = 18
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic                             kind,
   input  wire logic [ckbm_pkg::POS_W-1:0]       row,
   input  wire logic [ckbm_pkg::POS_W-1:0]       col,
   input  wire ckbm_pkg::rgb_type                fg,
   input  wire ckbm_pkg::rgb_type                bg,
   input  wire ckbm_pkg::queue_status_type       q_status,
   output logic                                  q_push,
   output logic [3*SUM_W+6*ckbm_pkg::CHAN_W-1:0] q_entry
);

   localparam int                 NSAMP   = 4 * SIDE;
   localparam logic [SUM_W-1:0]   SUM_MAX = SUM_W'(NSAMP * 255);

   logic [SUM_W-1:0] sum_r_ff, sum_g_ff, sum_b_ff;
   logic [SUM_W-1:0] sum_r_in, sum_g_in, sum_b_in;
   logic             accept;
   logic             on_row, on_col, restart;
   logic [SUM_W-1:0] d_r, d_g, d_b;

   // saturating add of v once per border line the pixel lies on
   function automatic logic [SUM_W-1:0] sat_add(
      input logic [SUM_W-1:0]           acc,
      input logic [ckbm_pkg::CHAN_W-1:0] v,
      input logic                       hit_row,
      input logic                       hit_col
   );
      logic [SUM_W:0] total;
      total = {1'b0, acc}
            + (hit_row ? (SUM_W+1)'(v) : '0)
            + (hit_col ? (SUM_W+1)'(v) : '0);
      if (total > {1'b0, SUM_MAX}) begin
         return SUM_MAX;
      end
      return total[SUM_W-1:0];
   endfunction

   // |NSAMP*v - sum|, never larger than SUM_MAX
   function automatic logic [SUM_W-1:0] abs_diff(
      input logic [ckbm_pkg::CHAN_W-1:0] v,
      input logic [SUM_W-1:0]           sum
   );
      logic [SUM_W:0] prod;
      logic [SUM_W:0] diff;
      logic [SUM_W:0] neg;
      prod = (SUM_W+1)'(NSAMP) * (SUM_W+1)'(v);
      diff = prod - {1'b0, sum};
      neg  = -diff;
      return diff[SUM_W] ? neg[SUM_W-1:0] : diff[SUM_W-1:0];
   endfunction

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   assign on_row  = (row == '0) || (32'(row) == 32'(SIDE - 1));
   assign on_col  = (col == '0) || (32'(col) == 32'(SIDE - 1));
   assign restart = (row == '0) && (col == '0);

   always_comb begin
      sum_r_in = sum_r_ff;
      sum_g_in = sum_g_ff;
      sum_b_in = sum_b_ff;
      if (accept && kind == ckbm_pkg::KIND_CAL) begin
         sum_r_in = sat_add(restart ? '0 : sum_r_ff, fg.red,   on_row, on_col);
         sum_g_in = sat_add(restart ? '0 : sum_g_ff, fg.green, on_row, on_col);
         sum_b_in = sat_add(restart ? '0 : sum_b_ff, fg.blue,  on_row, on_col);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_r_ff <= '0;
         sum_g_ff <= '0;
         sum_b_ff <= '0;
      end else begin
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
      end
   end

   // distances use the sums as they stand when the keying pixel arrives
   assign d_r = abs_diff(fg.red,   sum_r_ff);
   assign d_g = abs_diff(fg.green, sum_g_ff);
   assign d_b = abs_diff(fg.blue,  sum_b_ff);

   assign q_push  = accept && kind == ckbm_pkg::KIND_KEY;
   assign q_entry = {bg, fg, d_b, d_g, d_r};

endmodule : ckbm_front
`default_nettype wire

@@ sv/ckbm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ckbm_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
module ckbm_queue #(
   parameter int WIDTH = 102,
   parameter int DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                rd_data,
   output ckbm_pkg::queue_status_type      status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.full     = (32'(count_ff) == DEPTH);
   assign status.nonempty = (count_ff != '0);
   assign rd_data         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : ckbm_queue
`default_nettype wire

@@ sv/ckbm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ckbm_back
// Square the channel distances, compare against the squared threshold and
// select foreground or background into the output register.
// ---------------------------------------------------------------------------
module ckbm_back #(
   parameter int SIDE  = 256,
   parameter int SUM_W = 18
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [ckbm_pkg::THR_W-1:0]       csr_wr_data,
   input  wire ckbm_pkg::queue_status_type       q_status,
   input  wire logic [3*SUM_W+6*ckbm_pkg::CHAN_W-1:0] q_entry,
   output logic                                  q_pop,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output ckbm_pkg::rgb_type                     out_pixel,
   output logic                                  out_is_fg
);

   localparam int NSAMP = 4 * SIDE;
   localparam int LIM_W = ckbm_pkg::THR_W + $clog2(NSAMP + 1);
   localparam int SQ_W  = 2 * SUM_W;
   localparam int CMP_W = (SQ_W + 10 > 2 * LIM_W) ? SQ_W + 10 : 2 * LIM_W;

   ckbm_pkg::rgb_type          fg, bg;
   logic [SUM_W-1:0]           d_r, d_g, d_b;

   logic [ckbm_pkg::THR_W-1:0] thr_ff;
   logic [LIM_W-1:0]           lim_ff;
   logic [2*LIM_W-1:0]         limsq_ff;

   logic                       s1_valid_ff, s1_valid_in;
   logic [SQ_W-1:0]            sq_r_ff, sq_g_ff, sq_b_ff;
   ckbm_pkg::rgb_type          s1_fg_ff, s1_bg_ff;
   logic                       s1_ready;

   logic                       out_valid_ff, out_valid_in;
   ckbm_pkg::rgb_type          out_pixel_ff;
   logic                       out_is_fg_ff;
   logic                       s2_ready;
   logic [CMP_W-1:0]           sq_dist;
   logic                       keyed;

   assign {bg, fg, d_b, d_g, d_r} = q_entry;

   // threshold and its scaled square, rebuilt after every write
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= '0;
         lim_ff   <= '0;
         limsq_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         lim_ff   <= LIM_W'(thr_ff) * LIM_W'(NSAMP);
         limsq_ff <= (2*LIM_W)'(lim_ff) * (2*LIM_W)'(lim_ff);
      end
   end

   assign s2_ready    = !out_valid_ff || out_ready;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign q_pop       = q_status.nonempty && s1_ready;
   assign s1_valid_in = s1_ready ? q_status.nonempty : s1_valid_ff;

   // square stage
   always_ff @(posedge clock) begin
      if (q_pop) begin
         sq_r_ff  <= SQ_W'(d_r) * SQ_W'(d_r);
         sq_g_ff  <= SQ_W'(d_g) * SQ_W'(d_g);
         sq_b_ff  <= SQ_W'(d_b) * SQ_W'(d_b);
         s1_fg_ff <= fg;
         s1_bg_ff <= bg;
      end
   end

   // keyed when 256 * sum of squares < (T * NSAMP)^2
   assign sq_dist = (CMP_W'(sq_r_ff) + CMP_W'(sq_g_ff) + CMP_W'(sq_b_ff)) << 8;
   assign keyed   = sq_dist < CMP_W'(limsq_ff);

   assign out_valid_in = s2_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         out_pixel_ff <= keyed ? s1_bg_ff : s1_fg_ff;
         out_is_fg_ff <= !keyed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_is_fg = out_is_fg_ff;

endmodule : ckbm_back
`default_nettype wire

@@ sv/chroma_key_border_mean_composite.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chroma_key_border_mean_composite
// Chroma key against the mean color of the frame border.
// ---------------------------------------------------------------------------
// A square SIDE x SIDE frame streams in twice in raster order. Calibration
// transactions (tuser 0) add each border pixel's color into three
// saturating sums (corners count twice, sums restart at row 0, column 0)
// and produce no output. Keying transactions (tuser 1) each produce one
// output transaction: the background pixel when the pixel's RGB distance
// from the border mean is below csr_wr_data / 16, otherwise the foreground
// pixel, with tuser flagging which was kept. The block takes one pixel per
// clock while the queue is not full; a keying result passes through the
// two-entry queue, the squaring stage and the compare/output register.
// Threshold writes take effect for pixels accepted on the next cycle or
// later.
// ---------------------------------------------------------------------------
module chroma_key_border_mean_composite #(
   parameter int SIDE = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] row, [15:8] col, [23:16] fg_red, [31:24] fg_green,
   // [39:32] fg_blue, [47:40] bg_red, [55:48] bg_green, [63:56] bg_blue
   input  wire logic [63:0] req_tdata,
   // [0] kind
   input  wire logic [0:0]  req_tuser,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
   output logic [23:0]      rsp_tdata,
   // [0] is_foreground
   output logic [0:0]       rsp_tuser,
   // threshold register
   input  wire logic        csr_wr_en,
   input  wire logic [ckbm_pkg::THR_W-1:0] csr_wr_data
);

   // border sums must hold 4 * SIDE * 255
   localparam int SUM_W   = $clog2(4 * SIDE * 255 + 1);
   localparam int ENTRY_W = 3 * SUM_W + 6 * ckbm_pkg::CHAN_W;

   ckbm_pkg::rgb_type          fg, bg, out_pixel;
   ckbm_pkg::queue_status_type q_status;
   logic                       q_push, q_pop;
   logic [ENTRY_W-1:0]         q_wr_entry, q_rd_entry;
   logic                       out_is_fg;

   // unpack the request transaction
   assign fg.red   = req_tdata[23:16];
   assign fg.green = req_tdata[31:24];
   assign fg.blue  = req_tdata[39:32];
   assign bg.red   = req_tdata[47:40];
   assign bg.green = req_tdata[55:48];
   assign bg.blue  = req_tdata[63:56];

   // front: accept, accumulate border sums, compute channel distances
   ckbm_front #(
      .SIDE  (SIDE),
      .SUM_W (SUM_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .kind     (req_tuser[0]),
      .row      (req_tdata[7:0]),
      .col      (req_tdata[15:8]),
      .fg       (fg),
      .bg       (bg),
      .q_status (q_status),
      .q_push   (q_push),
      .q_entry  (q_wr_entry)
   );

   // decouple front and back so each side can stall on its own
   ckbm_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_entry),
      .pop     (q_pop),
      .rd_data (q_rd_entry),
      .status  (q_status)
   );

   // back: square, compare, select and hold the response
   ckbm_back #(
      .SIDE  (SIDE),
      .SUM_W (SUM_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_entry     (q_rd_entry),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pixel   (out_pixel),
      .out_is_fg   (out_is_fg)
   );

   // pack the response transaction
   assign rsp_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};
   assign rsp_tuser = out_is_fg;

endmodule : chroma_key_border_mean_composite
`default_nettype wire
